@@ sv/fas_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame animation sequencer package
// Shared types, codes and constants for the sequencer and its step logic.
// ----------------------------------------------------------------------------
package fas_pkg;

  localparam int MAX_FRAMES_DEF = 64;

  localparam int CMD_W      = 3;
  localparam int FCOUNT_W   = 7;   // frame_count register and internal frame index
  localparam int FRAME_W    = 6;   // frame field of a result
  localparam int PERIOD_W   = 16;
  localparam int LOOPS_W    = 16;
  localparam int TIME_W     = 32;
  localparam int REQ_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_FALLBACK = PERIOD_W'(100);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 3'd0,
    CMD_STOP = 3'd1,
    CMD_SET  = 3'd2,
    CMD_PLAY = 3'd3,
    CMD_BIND = 3'd4,
    CMD_INIT = 3'd5
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_COUNT    = 3'd0,
    CFG_PARK_FRAME     = 3'd1,
    CFG_DEFAULT_PERIOD = 3'd2,
    CFG_DEFAULT_LOOPS  = 3'd3,
    CFG_AUTOPLAY       = 3'd4
  } cfg_addr_t;

  typedef struct packed {
    logic [FCOUNT_W-1:0] frame_count;
    logic [FRAME_W-1:0]  park_frame;
    logic [PERIOD_W-1:0] default_period;
    logic [LOOPS_W-1:0]  default_loops;
    logic                autoplay;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic [TIME_W-1:0]          now_ms;
    logic signed [REQ_W-1:0]    frame_request;
    logic                       has_period;
    logic [PERIOD_W-1:0]        period_request;
    logic                       has_loops;
    logic [LOOPS_W-1:0]         loops_request;
  } item_t;

  typedef struct packed {
    logic [FCOUNT_W-1:0] frame;
    logic                running;
    logic [PERIOD_W-1:0] period;
    logic                loops_inf;
    logic [LOOPS_W-1:0]  loops;
    logic [TIME_W-1:0]   last_time;
  } anim_state_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               playing;
    logic               changed;
  } result_t;

endpackage

@@ sv/fas_step.sv @@
// ----------------------------------------------------------------------------
// Frame animation sequencer step
// Next-state and result logic for one command against the current state.
// ----------------------------------------------------------------------------
module fas_step #(
  parameter int MAX_FRAMES = fas_pkg::MAX_FRAMES_DEF
) (
  input  fas_pkg::cfg_t        cfg,
  input  fas_pkg::item_t       item,
  input  fas_pkg::anim_state_t st,
  output fas_pkg::anim_state_t st_next,
  output fas_pkg::result_t     res
);
  import fas_pkg::*;

  localparam int CMP_W = FCOUNT_W + 2;

  logic [FCOUNT_W-1:0] fc;
  logic [FCOUNT_W-1:0] fc_last;
  logic                has_frames;
  logic [FCOUNT_W-1:0] rest_ext;
  logic [FCOUNT_W-1:0] rest_or_zero;
  logic [FCOUNT_W-1:0] clamped;
  logic [FCOUNT_W-1:0] frame_inc;
  logic [PERIOD_W-1:0] cur_period;
  logic [PERIOD_W-1:0] dflt_period;
  logic [PERIOD_W-1:0] play_period;
  logic [LOOPS_W-1:0]  play_loops;
  logic [TIME_W-1:0]   elapsed;
  logic                changed;

  // Effective frame count: register value capped at MAX_FRAMES
  always_comb begin
    if (CMP_W'(cfg.frame_count) > CMP_W'(MAX_FRAMES)) begin
      fc = FCOUNT_W'(MAX_FRAMES);
    end else begin
      fc = cfg.frame_count;
    end
  end

  assign fc_last      = fc - FCOUNT_W'(1);
  assign has_frames   = (fc != '0);
  assign rest_ext     = FCOUNT_W'(cfg.park_frame);
  assign rest_or_zero = (rest_ext < fc) ? rest_ext : '0;
  assign frame_inc    = st.frame + FCOUNT_W'(1);
  assign cur_period   = (st.period != '0) ? st.period : PERIOD_FALLBACK;
  assign dflt_period  = (cfg.default_period != '0) ? cfg.default_period : PERIOD_FALLBACK;
  assign elapsed      = item.now_ms - st.last_time;

  // Clamp the signed request into the frame range
  always_comb begin
    if (!has_frames || item.frame_request[REQ_W-1]) begin
      clamped = '0;
    end else if (REQ_W'(item.frame_request) >= REQ_W'(fc)) begin
      clamped = fc_last;
    end else begin
      clamped = FCOUNT_W'(item.frame_request);
    end
  end

  always_comb begin
    if (item.has_period) begin
      play_period = (item.period_request != '0) ? item.period_request : PERIOD_FALLBACK;
    end else begin
      play_period = dflt_period;
    end
    play_loops = item.has_loops ? item.loops_request : cfg.default_loops;
  end

  always_comb begin
    st_next = st;
    changed = 1'b0;
    case (cmd_t'(item.command))
      CMD_TICK: begin
        if (st.running) begin
          if (!has_frames) begin
            st_next.running = 1'b0;
          end else if (st.last_time == '0) begin
            st_next.last_time = item.now_ms;
          end else if (elapsed >= TIME_W'(cur_period)) begin
            st_next.last_time = item.now_ms;
            changed           = 1'b1;
            if (frame_inc >= fc) begin
              st_next.frame = '0;
              if (!st.loops_inf && st.loops != '0) begin
                st_next.loops = st.loops - LOOPS_W'(1);
                // last loop finished: park on the rest frame
                if (st.loops == LOOPS_W'(1)) begin
                  st_next.running = 1'b0;
                  st_next.frame   = rest_or_zero;
                end
              end
            end else begin
              st_next.frame = frame_inc;
            end
          end
        end
      end
      CMD_STOP: begin
        st_next.running = 1'b0;
        st_next.frame   = rest_or_zero;
        changed         = 1'b1;
      end
      CMD_SET: begin
        st_next.frame   = clamped;
        st_next.running = 1'b0;
        changed         = 1'b1;
      end
      CMD_PLAY: begin
        if (has_frames) begin
          st_next.period    = play_period;
          st_next.loops_inf = (play_loops == '0);
          st_next.loops     = play_loops;
          st_next.running   = 1'b1;
          st_next.last_time = '0;
          st_next.frame     = '0;
        end
        changed = 1'b1;
      end
      CMD_BIND: begin
        if (!st.running && has_frames && clamped != st.frame) begin
          st_next.frame = clamped;
          changed       = 1'b1;
        end
      end
      CMD_INIT: begin
        st_next.running = 1'b0;
        if (has_frames && rest_ext >= fc) begin
          st_next.frame = fc_last;
        end else begin
          st_next.frame = rest_ext;
        end
        if (cfg.autoplay && has_frames) begin
          st_next.period    = dflt_period;
          st_next.loops_inf = (cfg.default_loops == '0);
          st_next.loops     = cfg.default_loops;
          st_next.running   = 1'b1;
          st_next.last_time = '0;
          st_next.frame     = '0;
        end
        changed = 1'b1;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  assign res.frame   = st_next.frame[FRAME_W-1:0];
  assign res.playing = st_next.running;
  assign res.changed = changed;

endmodule

@@ sv/frame_animation_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// Frame animation sequencer
// Holds the frame index of one animated image and steps it on timed ticks.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled and returns
// one result per request. A request is captured in an input register; the
// step logic (one 32-bit time subtract and compare, a frame increment and a
// clamp) then updates the state and loads the result register when the
// output can take it. Throughput is one request per clock while the output
// is not stalled; a stalled output holds the pipe while the input register
// still takes one more request.
module frame_animation_sequencer_top #(
  parameter int MAX_FRAMES = fas_pkg::MAX_FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_wr_en,
  input  logic [fas_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [fas_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // tdata: now_ms[31:0], frame_request[47:32], has_period[48],
  //        period_request[64:49], has_loops[65], loops_request[81:66], zero pad
  input  logic [fas_pkg::IN_DATA_W-1:0]       s_tdata,
  // tuser: command[2:0]
  input  logic [fas_pkg::CMD_W-1:0]           s_tuser,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tdata: frame[5:0], playing[6], changed[7]
  output logic [fas_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import fas_pkg::*;

  cfg_t        cfg;
  anim_state_t st;
  anim_state_t st_next;
  item_t       item;
  item_t       item_in;
  result_t     res;
  result_t     res_out;
  logic        item_valid;
  logic        advance;

  assign item_in.command        = s_tuser;
  assign item_in.now_ms         = s_tdata[31:0];
  assign item_in.frame_request  = s_tdata[47:32];
  assign item_in.has_period     = s_tdata[48];
  assign item_in.period_request = s_tdata[64:49];
  assign item_in.has_loops      = s_tdata[65];
  assign item_in.loops_request  = s_tdata[81:66];

  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_count    <= '0;
      cfg.park_frame     <= '0;
      cfg.default_period <= PERIOD_FALLBACK;
      cfg.default_loops  <= '0;
      cfg.autoplay       <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr_t'(cfg_addr))
        CFG_FRAME_COUNT:    cfg.frame_count    <= cfg_wdata[FCOUNT_W-1:0];
        CFG_PARK_FRAME:     cfg.park_frame     <= cfg_wdata[FRAME_W-1:0];
        CFG_DEFAULT_PERIOD: cfg.default_period <= cfg_wdata[PERIOD_W-1:0];
        CFG_DEFAULT_LOOPS:  cfg.default_loops  <= cfg_wdata[LOOPS_W-1:0];
        CFG_AUTOPLAY:       cfg.autoplay       <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_in;
    end
  end

  fas_step #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_step (
    .cfg     (cfg),
    .item    (item),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  // Animation state: advance only when the request moves to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      st.frame     <= '0;
      st.running   <= 1'b0;
      st.period    <= PERIOD_FALLBACK;
      st.loops_inf <= 1'b1;
      st.loops     <= '0;
      st.last_time <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_out <= res;
    end
  end

  assign m_tdata = {res_out.changed, res_out.playing, res_out.frame};

  // A finite loop count never sits at zero while playing
  a_finite_loops_nonzero: assert property (@(posedge clk) disable iff (rst)
    (st.running && !st.loops_inf) |-> (st.loops != '0))
    else $error("running with an exhausted finite loop count");

  // A request that moves on always shows up as a result
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("advanced request produced no result");

  // State holds while no request moves on
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("animation state changed without a request");

  // Reset leaves playback stopped and the pipe empty
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!st.running && !item_valid && !m_tvalid))
    else $error("reset did not clear control state");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame animation sequencer testbench
// Streams command requests into the sequencer, predicts the frame, playing
// and redraw flags of every result in step with the stream and compares them
// field by field. Runs a directed opening, then random play sequences and
// noise under several register settings and handshake pacing modes.
// ----------------------------------------------------------------------------
module testbench;
  import fas_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int RANDOM_PHASES = 8;
  localparam int MAX_SHOWN    = 10;
  localparam int MAX_FRAMES   = MAX_FRAMES_DEF;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  always #CLK_HALF clk = ~clk;

  frame_animation_sequencer_top #(
    .MAX_FRAMES(MAX_FRAMES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Register copies and animation state of the predictor
  logic [FCOUNT_W-1:0] cfg_frames = '0;
  logic [FRAME_W-1:0]  cfg_rest = '0;
  logic [PERIOD_W-1:0] cfg_period = PERIOD_FALLBACK;
  logic [LOOPS_W-1:0]  cfg_loops = '0;
  logic                cfg_auto = 1'b0;

  logic [FCOUNT_W-1:0] an_frame = '0;
  logic                an_running = 1'b0;
  logic [PERIOD_W-1:0] an_period = PERIOD_FALLBACK;
  logic                an_loops_inf = 1'b1;
  logic [LOOPS_W-1:0]  an_loops = '0;
  logic [TIME_W-1:0]   an_last = '0;

  item_t      request_queue[$];
  result_t    expected_frames[$];
  idle_mode_t idle_mode = IDLE_NONE;
  logic       request_taken = 1'b0;
  logic [TIME_W-1:0] clock_ms;
  int cycle_count = 0;
  int items_taken = 0;
  int mismatches = 0;
  int settings_count = 0;

  function automatic logic [FCOUNT_W-1:0] rest_or_zero(input logic [FCOUNT_W-1:0] fc);
    return (FCOUNT_W'(cfg_rest) < fc) ? FCOUNT_W'(cfg_rest) : '0;
  endfunction

  function automatic logic [FCOUNT_W-1:0] clamp_req(input logic signed [REQ_W-1:0] r,
                                                     input logic [FCOUNT_W-1:0] fc);
    if (fc == 0 || r < 0) return '0;
    if (int'(r) >= int'(fc)) return fc - 1'b1;
    return FCOUNT_W'(r);
  endfunction

  function automatic void start_show(input logic [PERIOD_W-1:0] per,
                                     input logic [LOOPS_W-1:0] loops);
    an_period    = (per != 0) ? per : PERIOD_FALLBACK;
    an_loops_inf = (loops == 0);
    an_loops     = loops;
    an_running   = 1'b1;
    an_last      = '0;
    an_frame     = '0;
  endfunction

  // Advance the predicted animation by one request and return its result
  function automatic void predict_frame(input item_t req, output result_t res);
    logic [FCOUNT_W-1:0] fc;
    logic [FCOUNT_W-1:0] nf;
    logic [TIME_W-1:0]   elapsed;
    logic [PERIOD_W-1:0] per;
    logic [LOOPS_W-1:0]  lp;
    logic                redraw;
    fc = (cfg_frames > FCOUNT_W'(MAX_FRAMES)) ? FCOUNT_W'(MAX_FRAMES) : cfg_frames;
    redraw = 1'b0;
    case (req.command)
      CMD_TICK: begin
        if (an_running) begin
          if (fc == 0) begin
            an_running = 1'b0;
          end else if (an_last == 0) begin
            // a latch at time zero leaves the time unlatched
            an_last = req.now_ms;
          end else begin
            per = (an_period != 0) ? an_period : PERIOD_FALLBACK;
            elapsed = req.now_ms - an_last;
            if (elapsed >= TIME_W'(per)) begin
              an_last = req.now_ms;
              nf = an_frame + 1'b1;
              if (nf >= fc) begin
                nf = '0;
                if (!an_loops_inf && an_loops != 0) begin
                  an_loops = an_loops - 1'b1;
                  if (an_loops == 0) begin
                    an_running = 1'b0;
                    nf = rest_or_zero(fc);
                  end
                end
              end
              an_frame = nf;
              redraw = 1'b1;
            end
          end
        end
      end
      CMD_STOP: begin
        an_running = 1'b0;
        an_frame = rest_or_zero(fc);
        redraw = 1'b1;
      end
      CMD_SET: begin
        an_frame = clamp_req(req.frame_request, fc);
        an_running = 1'b0;
        redraw = 1'b1;
      end
      CMD_PLAY: begin
        if (fc != 0) begin
          per = req.has_period ? req.period_request
                               : ((cfg_period != 0) ? cfg_period : PERIOD_FALLBACK);
          lp = req.has_loops ? req.loops_request : cfg_loops;
          start_show(per, lp);
        end
        redraw = 1'b1;
      end
      CMD_BIND: begin
        if (!an_running && fc != 0) begin
          nf = clamp_req(req.frame_request, fc);
          if (nf != an_frame) begin
            an_frame = nf;
            redraw = 1'b1;
          end
        end
      end
      CMD_INIT: begin
        an_running = 1'b0;
        if (fc != 0 && FCOUNT_W'(cfg_rest) >= fc) an_frame = fc - 1'b1;
        else an_frame = FCOUNT_W'(cfg_rest);
        if (cfg_auto && fc != 0)
          start_show((cfg_period != 0) ? cfg_period : PERIOD_FALLBACK, cfg_loops);
        redraw = 1'b1;
      end
      default: begin
      end
    endcase
    res.frame   = an_frame[FRAME_W-1:0];
    res.playing = an_running;
    res.changed = redraw;
  endfunction

  function automatic logic send_idle();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 77;
      IDLE_BOTH: return $urandom_range(0, 99) < 35;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic recv_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 77;
      IDLE_BOTH: return $urandom_range(0, 99) < 35;
      default:   return 1'b0;
    endcase
  endfunction

  // Drive requests and the result ready at the falling edge
  always @(negedge clk) begin : drive
    item_t nxt;
    if (!rst) begin
      if (!s_tvalid || request_taken) begin
        if (request_queue.size() != 0 && !send_idle()) begin
          nxt = request_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'd0, nxt.loops_request, nxt.has_loops, nxt.period_request,
                       nxt.has_period, nxt.frame_request, nxt.now_ms};
          s_tuser  <= nxt.command;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= !recv_stall();
    end
  end

  // Predict on accepted requests, check accepted results
  always @(posedge clk) begin : watch
    item_t   req;
    result_t want;
    result_t got;
    cycle_count++;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req.command        = s_tuser;
        req.now_ms         = s_tdata[31:0];
        req.frame_request  = s_tdata[47:32];
        req.has_period     = s_tdata[48];
        req.period_request = s_tdata[64:49];
        req.has_loops      = s_tdata[65];
        req.loops_request  = s_tdata[81:66];
        predict_frame(req, want);
        expected_frames.push_back(want);
        items_taken++;
      end
      request_taken = s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        got.frame   = m_tdata[5:0];
        got.playing = m_tdata[6];
        got.changed = m_tdata[7];
        if (expected_frames.size() == 0) begin
          if (mismatches < MAX_SHOWN)
            $display("cycle %0d: result with nothing pending: frame %0d playing %0b changed %0b",
                     cycle_count, got.frame, got.playing, got.changed);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (got.frame !== want.frame || got.playing !== want.playing ||
              got.changed !== want.changed) begin
            if (mismatches < MAX_SHOWN)
              $display("cycle %0d: expected frame %0d playing %0b changed %0b, got %0d %0b %0b",
                       cycle_count, want.frame, want.playing, want.changed,
                       got.frame, got.playing, got.changed);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("frame_animation_sequencer_top test failed");
    $finish;
  end

  function automatic void push_req(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                                   input logic [REQ_W-1:0] fr, input logic hp,
                                   input logic [PERIOD_W-1:0] pr, input logic hl,
                                   input logic [LOOPS_W-1:0] lr);
    item_t it;
    it.command        = cmd;
    it.now_ms         = now;
    it.frame_request  = fr;
    it.has_period     = hp;
    it.period_request = pr;
    it.has_loops      = hl;
    it.loops_request  = lr;
    request_queue.push_back(it);
  endfunction

  // Random filler in the fields a tick ignores
  function automatic void push_tick(input logic [TIME_W-1:0] now);
    push_req(CMD_TICK, now, REQ_W'($urandom), 1'($urandom), PERIOD_W'($urandom),
             1'($urandom), LOOPS_W'($urandom));
  endfunction

  function automatic logic [REQ_W-1:0] pick_frame_req();
    int v;
    if ($urandom_range(0, 3) == 0) return REQ_W'($urandom);
    v = int'($urandom_range(0, 80)) - 8;
    return REQ_W'(v);
  endfunction

  // Play request followed by a run of ticks paced around the period
  function automatic int add_show();
    logic [PERIOD_W-1:0] per;
    logic [LOOPS_W-1:0]  loops;
    logic                hp;
    logic                hl;
    logic [TIME_W-1:0]   step_ms;
    int                  ticks;
    int                  made;
    hp = 1'($urandom_range(0, 1));
    hl = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       per = '0;
      1:       per = PERIOD_W'($urandom);
      2:       per = '1;
      default: per = PERIOD_W'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 7))
      0:       loops = '0;
      1:       loops = LOOPS_W'($urandom);
      default: loops = LOOPS_W'($urandom_range(1, 3));
    endcase
    push_req(CMD_PLAY, $urandom, REQ_W'($urandom), hp, per, hl, loops);
    step_ms = hp ? TIME_W'(per) : TIME_W'(cfg_period);
    if (step_ms == 0) step_ms = 100;
    // sometimes run the ticks across the wrap of the millisecond counter
    if ($urandom_range(0, 9) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * step_ms);
    ticks = $urandom_range(4, 40);
    made = 1;
    repeat (ticks) begin
      case ($urandom_range(0, 19))
        0: push_tick('0);
        1: push_req(CMD_W'($urandom_range(1, 5)), clock_ms, pick_frame_req(),
                    1'($urandom), PERIOD_W'($urandom_range(0, 30)), 1'($urandom),
                    LOOPS_W'($urandom_range(0, 3)));
        2, 3, 4: begin
          clock_ms += $urandom_range(0, step_ms - 1);
          push_tick(clock_ms);
        end
        default: begin
          clock_ms += step_ms + $urandom_range(0, 2);
          push_tick(clock_ms);
        end
      endcase
      made++;
    end
    return made;
  endfunction

  function automatic void add_random_items(input int count);
    logic [CMD_W-1:0] cmd;
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 70) begin
        made += add_show();
      end else begin
        cmd = CMD_W'($urandom_range(0, 7));
        push_req(cmd, $urandom, $urandom_range(0, 1) ? pick_frame_req() : REQ_W'($urandom),
                 1'($urandom), PERIOD_W'($urandom), 1'($urandom), LOOPS_W'($urandom));
        // ignored codes do not count
        if (cmd <= CMD_INIT) made++;
      end
    end
  endfunction

  task automatic write_reg(input cfg_addr_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_FRAME_COUNT:    cfg_frames = value[FCOUNT_W-1:0];
      CFG_PARK_FRAME:     cfg_rest   = value[FRAME_W-1:0];
      CFG_DEFAULT_PERIOD: cfg_period = value[PERIOD_W-1:0];
      CFG_DEFAULT_LOOPS:  cfg_loops  = value[LOOPS_W-1:0];
      CFG_AUTOPLAY:       cfg_auto   = value[0];
      default: begin
      end
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] fc, input logic [CFG_DATA_W-1:0] rest,
                           input logic [CFG_DATA_W-1:0] per, input logic [CFG_DATA_W-1:0] lp,
                           input logic [CFG_DATA_W-1:0] auto_en);
    write_reg(CFG_FRAME_COUNT, fc);
    write_reg(CFG_PARK_FRAME, rest);
    write_reg(CFG_DEFAULT_PERIOD, per);
    write_reg(CFG_DEFAULT_LOOPS, lp);
    write_reg(CFG_AUTOPLAY, auto_en);
    settings_count++;
  endtask

  // Hold until every request is in and every result is out, then let the pipe settle
  task automatic drain();
    while (request_queue.size() != 0 || s_tvalid || expected_frames.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] fc_w;
    logic [CFG_DATA_W-1:0] rest_w;
    logic [CFG_DATA_W-1:0] per_w;
    logic [CFG_DATA_W-1:0] lp_w;
    logic [CFG_DATA_W-1:0] auto_w;
    clock_ms = $urandom;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // no frames, registers at reset
    push_req(CMD_TICK, 32'd500, '0, 1'b0, '0, 1'b0, '0);
    push_req(CMD_STOP, '0, '0, 1'b0, '0, 1'b0, '0);
    push_req(CMD_SET, '0, 16'sh8000, 1'b0, '0, 1'b0, '0);
    push_req(CMD_SET, '0, 16'sh7FFF, 1'b0, '0, 1'b0, '0);
    push_req(CMD_PLAY, '0, '0, 1'b1, 16'd5, 1'b1, 16'd2);
    push_req(CMD_BIND, '0, 16'sd5, 1'b0, '0, 1'b0, '0);
    push_req(CMD_INIT, '0, '0, 1'b0, '0, 1'b0, '0);
    push_req(3'd6, 32'hFFFF_FFFF, '1, 1'b1, '1, 1'b1, '1);
    push_req(3'd7, 32'hFFFF_FFFF, '1, 1'b1, '1, 1'b1, '1);
    drain();

    // five frames, rest frame out of range, zero default period, one loop, autoplay
    configure(16'd5, 16'd63, 16'd0, 16'd1, 16'd1);
    push_req(CMD_INIT, '0, '0, 1'b0, '0, 1'b0, '0);
    push_tick(32'd0);
    push_tick(32'd1000);
    push_tick(32'd1099);
    push_tick(32'd1100);
    push_req(CMD_BIND, '0, 16'sd3, 1'b0, '0, 1'b0, '0);
    push_req(CMD_PLAY, '0, '0, 1'b1, 16'd0, 1'b1, 16'd1);
    for (int t = 2000; t <= 2500; t += 100) push_tick(TIME_W'(t));
    push_req(CMD_STOP, '0, '0, 1'b0, '0, 1'b0, '0);
    push_req(CMD_BIND, '0, 16'sd3, 1'b0, '0, 1'b0, '0);
    push_req(CMD_BIND, '0, 16'sd3, 1'b0, '0, 1'b0, '0);
    push_req(CMD_SET, '0, 16'shFFFF, 1'b0, '0, 1'b0, '0);
    push_req(CMD_SET, '0, 16'sh7FFF, 1'b0, '0, 1'b0, '0);
    push_req(CMD_PLAY, '0, '0, 1'b0, '0, 1'b0, '0);
    drain();

    // drop the frames while still playing
    configure(16'd0, 16'd7, 16'd100, 16'd0, 16'd1);
    push_tick(32'd3000);
    push_req(CMD_INIT, '0, '0, 1'b0, '0, 1'b0, '0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(16'd1, 16'd0, 16'd1, 16'd0, 16'd1);
        1: configure(16'd64, 16'd63, 16'hFFFF, 16'hFFFF, 16'd0);
        2: configure(16'd127, 16'd63, 16'd0, 16'd1, 16'd1);
        default: begin
          fc_w   = CFG_DATA_W'($urandom_range(1, 9));
          rest_w = CFG_DATA_W'($urandom_range(0, 12));
          per_w  = ($urandom_range(0, 4) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 40));
          lp_w   = CFG_DATA_W'($urandom_range(0, 3));
          auto_w = CFG_DATA_W'($urandom_range(0, 1));
          // junk above the register width must be dropped
          if ($urandom_range(0, 1) != 0) begin
            fc_w   |= CFG_DATA_W'($urandom) & 16'hFF80;
            rest_w |= CFG_DATA_W'($urandom) & 16'hFFC0;
            auto_w |= CFG_DATA_W'($urandom) & 16'hFFFE;
          end
          configure(fc_w, rest_w, per_w, lp_w, auto_w);
        end
      endcase
      idle_mode = idle_mode_t'(p % 4);
      push_req(CMD_INIT, '0, '0, 1'b0, '0, 1'b0, '0);
      add_random_items(RANDOM_ITEMS / RANDOM_PHASES);
      drain();
    end

    idle_mode = IDLE_NONE;
    repeat (8) @(negedge clk);
    $display("Ran %0d requests over %0d register settings and four pacing modes",
             items_taken, settings_count);
    $display("Mismatches: %0d, results still pending: %0d", mismatches, expected_frames.size());
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("frame_animation_sequencer_top test passed");
    end else begin
      $display("frame_animation_sequencer_top test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/fas_pkg.sv
sv/fas_step.sv
sv/frame_animation_sequencer_top.sv
tb/sv/testbench.sv
